/* rtl/core/indexed_insert_remove_list_top_assert.svh */
// Assertion macros for the indexed insert/remove list.
// Each macro expects clk and arst_n in scope at the point of use.
`ifndef INDEXED_INSERT_REMOVE_LIST_TOP_ASSERT_SVH
`define INDEXED_INSERT_REMOVE_LIST_TOP_ASSERT_SVH

// Antecedent holds in a cycle -> consequent holds in the same cycle.
`define ILST_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent holds in a cycle -> consequent holds in the next cycle.
`define ILST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/ilst_pkg.sv */
// Shared types and codes for the indexed insert/remove list.
// No dependencies; used by ilst_cell and indexed_insert_remove_list_top.
package ilst_pkg;

	typedef enum logic [2:0] {
		MODE_INSERT      = 3'd0,
		MODE_APPEND      = 3'd1,
		MODE_REMOVE_AT   = 3'd2,
		MODE_REMOVE_LAST = 3'd3,
		MODE_READ        = 3'd4,
		MODE_WRITE       = 3'd5,
		MODE_FIND        = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_FULL  = 2'd2,
		STATUS_EMPTY = 2'd3
	} status_t;

	// Per-beat command broadcast to every cell of the row.
	typedef struct packed {
		logic ins;  // open a slot at the position, move later entries up
		logic rem;  // close the slot at the position, move later entries down
		logic wr;   // overwrite the entry at the position
	} cell_ctrl_t;

endpackage

/* rtl/core/ilst_cell.sv */
// One storage cell of the list row: holds a single entry and trades it with its neighbors.
// Depends on ilst_pkg (cell_ctrl_t).
module ilst_cell #(
	parameter int DATA_WIDTH = 32,
	parameter int PW         = 7,
	parameter int INDEX      = 0
) (
	input  logic                   clk,
	input  ilst_pkg::cell_ctrl_t   ctrl,
	input  logic [PW-1:0]          pos,
	input  logic [DATA_WIDTH-1:0]  value,
	input  logic [DATA_WIDTH-1:0]  lower,
	input  logic [DATA_WIDTH-1:0]  upper,
	output logic [DATA_WIDTH-1:0]  q,
	output logic                   match,
	output logic [DATA_WIDTH-1:0]  rd_data
);

	localparam logic [PW-1:0] ME = PW'(INDEX);

	logic [DATA_WIDTH-1:0] entry_q;
	logic                  at_pos;
	logic                  past_pos;

	assign at_pos   = (pos == ME);
	assign past_pos = (pos < ME);

	always_ff @(posedge clk) begin
		priority if (ctrl.ins && at_pos) begin
			entry_q <= value;
		end else if (ctrl.ins && past_pos) begin
			entry_q <= lower;
		end else if (ctrl.rem && (at_pos || past_pos)) begin
			entry_q <= upper;
		end else if (ctrl.wr && at_pos) begin
			entry_q <= value;
		end else begin
			// hold
			entry_q <= entry_q;
		end
	end

	assign q       = entry_q;
	assign match   = (entry_q == value);
	assign rd_data = at_pos ? entry_q : '0;

endmodule

/* rtl/core/indexed_insert_remove_list_top.sv */
// Indexed insert/remove list: a row of DEPTH cells that shift, load and compare in parallel.
// Each request beat is registered in stage 1, then in the output register that drives its result beat.
// Throughput: one request per cycle while in_stall is low; row updates happen in the accept cycle.
// Reset (arst_n low): count zero, both stages empty; entries hold garbage until written.
// Depends on ilst_pkg, ilst_cell and indexed_insert_remove_list_top_assert.svh.
module indexed_insert_remove_list_top #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [5:0]  position,
	input  logic [31:0] value,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] data,
	output logic [5:0]  found_position,
	output logic        found,
	output logic [6:0]  count,
	output logic [1:0]  status
);

	// Count is wide enough to hold DEPTH itself; compares run at least as wide as the
	// six-bit position so an out-of-range position never aliases into the list.
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > 6) ? CW : 6;
	localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// ---------------------------------------------------------------- state
	logic [CW-1:0]          entry_count_q;

	logic                   valid_s1;
	logic [DATA_WIDTH-1:0]  data_s1;
	logic [DEPTH-1:0]       match_s1;
	logic [CW-1:0]          count_s1;
	ilst_pkg::status_t      status_s1;

	logic                   out_valid_q;
	logic [DATA_WIDTH-1:0]  data_q;
	logic [IW-1:0]          fpos_q;
	logic                   found_q;
	logic [CW-1:0]          count_q;
	ilst_pkg::status_t      status_q;

	// ---------------------------------------------------------------- handshake
	// Stage 1 moves to the output register when that register is empty or being drained.
	// The accept side stalls only when stage 1 is full and cannot move.
	logic in_fire;
	logic s1_move;

	assign s1_move  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_move;
	assign in_fire  = in_valid && !in_stall;

	// ---------------------------------------------------------------- decode
	logic [CMPW-1:0]        pos_w;
	logic [CMPW-1:0]        cnt_w;
	logic                   full;
	logic                   empty;
	logic [DATA_WIDTH-1:0]  val_w;

	ilst_pkg::status_t      status_d;
	ilst_pkg::cell_ctrl_t   op;
	logic                   rd;
	logic                   fnd;
	logic [CW-1:0]          peff;

	assign pos_w = CMPW'(position);
	assign cnt_w = CMPW'(entry_count_q);
	assign full  = (entry_count_q == CW'(DEPTH));
	assign empty = (entry_count_q == '0);
	assign val_w = DATA_WIDTH'(value);

	always_comb begin
		status_d = ilst_pkg::STATUS_OK;
		op       = '0;
		rd       = 1'b0;
		fnd      = 1'b0;
		peff     = pos_w[CW-1:0];
		unique case (ilst_pkg::mode_t'(mode))
			ilst_pkg::MODE_INSERT: begin
				// Full wins over a bad position; position equal to count appends.
				if (full) begin
					status_d = ilst_pkg::STATUS_FULL;
				end else if (pos_w > cnt_w) begin
					status_d = ilst_pkg::STATUS_RANGE;
				end else begin
					op.ins = 1'b1;
				end
			end
			ilst_pkg::MODE_APPEND: begin
				peff = entry_count_q;
				if (full) begin
					status_d = ilst_pkg::STATUS_FULL;
				end else begin
					op.ins = 1'b1;
				end
			end
			ilst_pkg::MODE_REMOVE_AT: begin
				// Empty wins over a bad position.
				if (empty) begin
					status_d = ilst_pkg::STATUS_EMPTY;
				end else if (pos_w >= cnt_w) begin
					status_d = ilst_pkg::STATUS_RANGE;
				end else begin
					op.rem = 1'b1;
					rd     = 1'b1;
				end
			end
			ilst_pkg::MODE_REMOVE_LAST: begin
				peff = entry_count_q - CW'(1);
				if (empty) begin
					status_d = ilst_pkg::STATUS_EMPTY;
				end else begin
					op.rem = 1'b1;
					rd     = 1'b1;
				end
			end
			ilst_pkg::MODE_READ: begin
				if (pos_w >= cnt_w) begin
					status_d = ilst_pkg::STATUS_RANGE;
				end else begin
					rd = 1'b1;
				end
			end
			ilst_pkg::MODE_WRITE: begin
				if (pos_w >= cnt_w) begin
					status_d = ilst_pkg::STATUS_RANGE;
				end else begin
					op.wr = 1'b1;
				end
			end
			ilst_pkg::MODE_FIND: begin
				fnd = 1'b1;
			end
			default: begin
				// unused code: no change, all-zero result apart from count
			end
		endcase
	end

	// Gate the broadcast command with the accept so a stalled beat touches nothing.
	ilst_pkg::cell_ctrl_t ctrl;
	assign ctrl = in_fire ? op : '0;

	// ---------------------------------------------------------------- cell row
	logic [DATA_WIDTH-1:0] cell_q  [DEPTH];
	logic [DATA_WIDTH-1:0] cell_rd [DEPTH];
	logic [DEPTH-1:0]      cell_match;
	logic [DEPTH-1:0]      match_live;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [DATA_WIDTH-1:0] lower;
		logic [DATA_WIDTH-1:0] upper;

		// Cell zero has nothing below it (it only ever loads the new value on insert);
		// the last cell has nothing above it, so it holds its own entry on remove.
		if (g == 0) begin : g_first
			assign lower = val_w;
		end else begin : g_mid_lo
			assign lower = cell_q[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign upper = cell_q[g];
		end else begin : g_mid_hi
			assign upper = cell_q[g+1];
		end

		ilst_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.PW         (CW),
			.INDEX      (g)
		) u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.pos     (peff),
			.value   (val_w),
			.lower   (lower),
			.upper   (upper),
			.q       (cell_q[g]),
			.match   (cell_match[g]),
			.rd_data (cell_rd[g])
		);

		// Only live entries may answer a search.
		assign match_live[g] = cell_match[g] && (entry_count_q > CW'(g));
	end

	// At most one cell drives a nonzero read term, so an OR gathers the read beat.
	logic [DATA_WIDTH-1:0] rd_bus;
	always_comb begin
		rd_bus = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_bus = rd_bus | cell_rd[i];
		end
	end

	// ---------------------------------------------------------------- count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (ctrl.ins) begin
			entry_count_q <= entry_count_q + CW'(1);
		end else if (ctrl.rem) begin
			entry_count_q <= entry_count_q - CW'(1);
		end
	end

	// ---------------------------------------------------------------- stage 1
	// Capture read data, raw match vector and the post-request count.
	logic [CW-1:0] count_next;
	always_comb begin
		count_next = entry_count_q;
		if (op.ins) begin
			count_next = entry_count_q + CW'(1);
		end else if (op.rem) begin
			count_next = entry_count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_s1   <= rd ? rd_bus : '0;
			match_s1  <= fnd ? match_live : '0;
			count_s1  <= count_next;
			status_s1 <= status_d;
		end
	end

	// ---------------------------------------------------------------- find encode
	// Lowest matching position wins: scan down so the last hit kept is the lowest.
	logic [IW-1:0] fidx;
	always_comb begin
		fidx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match_s1[i]) begin
				fidx = IW'(i);
			end
		end
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			data_q   <= data_s1;
			fpos_q   <= fidx;
			found_q  <= |match_s1;
			count_q  <= count_s1;
			status_q <= status_s1;
		end
	end

	assign out_valid      = out_valid_q;
	assign data           = 32'(data_q);
	assign found_position = 6'(fpos_q);
	assign found          = found_q;
	assign count          = 7'(count_q);
	assign status         = status_q;

	// ---------------------------------------------------------------- checks
`include "indexed_insert_remove_list_top_assert.svh"

	`ILST_ASSERT_NOW(a_count_bound, 1'b1, entry_count_q <= CW'(DEPTH), "list count above depth")
	`ILST_ASSERT_NEXT(a_ins_count, ctrl.ins, entry_count_q == $past(entry_count_q) + CW'(1), "insert did not grow count")
	`ILST_ASSERT_NOW(a_found_ok, out_valid_q && found_q, status_q == ilst_pkg::STATUS_OK, "find hit with error status")
	`ILST_ASSERT_NOW(a_err_no_data, out_valid_q && (status_q != ilst_pkg::STATUS_OK), data_q == '0, "error beat carries data")

endmodule
